// ===== rtl/rdsr_pkg.sv =====
// ----------------------------------------------------------------------------
// rdsr_pkg
// Shared widths, register indexes, reset values and the command that the
// row compare hands to the span generator.
// ----------------------------------------------------------------------------
package rdsr_pkg;

  // field widths
  localparam int unsigned RowBitsW = 64;
  localparam int unsigned RowIdxW  = 5;
  localparam int unsigned CoordW   = 11;
  localparam int unsigned WidthW   = 10;
  localparam int unsigned ScaleW   = 4;
  localparam int unsigned OriginW  = 10;
  localparam int unsigned ColIdxW  = 6;
  localparam int unsigned RunLenW  = 7;

  // stream and configuration port widths
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgOriginX    = 2'd0,
    CfgOriginY    = 2'd1,
    CfgPixelScale = 2'd2
  } cfg_idx_e;

  // register reset values
  localparam logic [OriginW-1:0] ResetOriginX = 10'd0;
  localparam logic [OriginW-1:0] ResetOriginY = 10'd88;
  localparam logic [ScaleW-1:0]  ResetScale   = 4'd5;

  // work handed from the row compare to the span generator
  typedef struct packed {
    logic [RowBitsW-1:0] off_bits;
    logic [RowBitsW-1:0] on_bits;
    logic [CoordW-1:0]   rect_y;
    logic [ScaleW-1:0]   scale;
    logic [OriginW-1:0]  origin_x;
  } span_cmd_t;

endpackage

// ===== rtl/row_diff_span_renderer.sv =====
// ----------------------------------------------------------------------------
// row_diff_span_renderer
// Compares each incoming framebuffer row with its last shown copy and emits
// black rectangles for pixels turned off, then white ones for pixels turned on.
//
// Usage:
// - s_axis carries one row per transaction: row index and 64 pixel bits,
//   bit 63 being column 0. m_axis carries one rectangle per transaction,
//   tuser is the colour (1 white) and tlast marks the final one of the row.
// - cfg writes origin_x, origin_y and pixel_scale while the block is idle;
//   cfg_ready_o is always high.
// - A row is accepted, then read from the store and compared, after which
//   the scan walks 1 to COLUMNS positions of the turned-off word and 1 to
//   COLUMNS of the turned-on word, one column a cycle unless a closing run
//   waits on a stalled receiver, stopping a word early once no lit bit is
//   left. A rectangle enters the output register when its run closes.
// - Unchanged or out-of-range rows give no rectangles and no store update.
// - Reset clears the row store through per-row valid bits, so the first
//   frame paints every lit pixel; configuration returns to its reset values.
// - A stalled receiver holds the rectangle in the output register and halts
//   the scan at its next closing run; the next row waits until the scan ends.
// ----------------------------------------------------------------------------
module row_diff_span_renderer
  import rdsr_pkg::*;
#(
  parameter int unsigned ROWS    = 32,
  parameter int unsigned COLUMNS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // row input
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // row_index[4:0], row_bits[68:5]
  // rectangle output
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // rect_x[10:0], rect_y[21:11],
                                              // rect_w[31:22], rect_h[35:32]
  output logic                m_axis_tuser,   // lit_color
  output logic                m_axis_tlast    // last_span
);

  localparam int unsigned AddrW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [RowBitsW-1:0] ColMask = ~RowBitsW'(0) << (RowBitsW - COLUMNS);

  typedef enum logic {
    StIdle,
    StLookup
  } state_e;

  state_e              state_q;
  logic [RowIdxW-1:0]  row_q;
  logic [RowBitsW-1:0] cur_q;
  logic                in_range_q;
  logic [OriginW-1:0]  origin_x_q;
  logic [OriginW-1:0]  origin_y_q;
  logic [ScaleW-1:0]   pixel_scale_q;

  logic                accept;
  logic                gen_busy;
  logic [RowIdxW:0]    in_row_ext;
  logic [RowIdxW:0]    cur_row_ext;
  logic                in_range;
  logic [RowBitsW-1:0] prev_bits;
  logic                start;
  logic [ScaleW-1:0]   scale_eff;
  logic [8:0]          y_prod;
  span_cmd_t           cmd;
  logic [CoordW-1:0]   rect_x;
  logic [CoordW-1:0]   rect_y;
  logic [WidthW-1:0]   rect_w;
  logic [ScaleW-1:0]   rect_h;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q    <= ResetOriginX;
      origin_y_q    <= ResetOriginY;
      pixel_scale_q <= ResetScale;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgOriginX:    origin_x_q    <= cfg_data_i;
        CfgOriginY:    origin_y_q    <= cfg_data_i;
        CfgPixelScale: pixel_scale_q <= cfg_data_i[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  // input transaction and row range check
  assign s_axis_tready = (state_q == StIdle) && !gen_busy;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_row_ext    = {1'b0, s_axis_tdata[RowIdxW-1:0]};
  assign cur_row_ext   = {1'b0, row_q};
  assign in_range      = {1'b0, in_row_ext} < (RowIdxW + 2)'(ROWS);

  // compare and command build
  always_comb begin
    scale_eff    = (pixel_scale_q == '0) ? ScaleW'(1) : pixel_scale_q;
    y_prod       = 9'(row_q) * 9'(scale_eff);
    start        = (state_q == StLookup) && in_range_q && (cur_q != prev_bits);
    cmd.off_bits = prev_bits & ~cur_q;
    cmd.on_bits  = cur_q & ~prev_bits;
    cmd.rect_y   = CoordW'(origin_y_q) + CoordW'(y_prod);
    cmd.scale    = scale_eff;
    cmd.origin_x = origin_x_q;
  end

  // lookup sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      row_q      <= '0;
      cur_q      <= '0;
      in_range_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (accept) begin
            state_q    <= StLookup;
            row_q      <= s_axis_tdata[RowIdxW-1:0];
            cur_q      <= s_axis_tdata[RowIdxW +: RowBitsW] & ColMask;
            in_range_q <= in_range;
          end
        end
        StLookup: state_q <= StIdle;
        default:  state_q <= StIdle;
      endcase
    end
  end

  rdsr_row_store #(
    .ROWS (ROWS)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (in_row_ext[AddrW-1:0]),
    .rd_data_o (prev_bits),
    .wr_en_i   (start),
    .wr_addr_i (cur_row_ext[AddrW-1:0]),
    .wr_data_i (cur_q)
  );

  rdsr_span_gen #(
    .COLUMNS (COLUMNS)
  ) u_span_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .cmd_i       (cmd),
    .busy_o      (gen_busy),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .rect_x_o    (rect_x),
    .rect_y_o    (rect_y),
    .rect_w_o    (rect_w),
    .rect_h_o    (rect_h),
    .lit_color_o (m_axis_tuser),
    .last_span_o (m_axis_tlast)
  );

  // output packing, padded to whole bytes
  assign m_axis_tdata = {4'b0000, rect_h, rect_w, rect_y, rect_x};

endmodule

// ===== rtl/rdsr_row_store.sv =====
// ----------------------------------------------------------------------------
// rdsr_row_store
// Copy of the last shown framebuffer rows: one synchronous memory with a
// registered read and a valid bit per row, so a row never written reads zero.
// ----------------------------------------------------------------------------
module rdsr_row_store
  import rdsr_pkg::*;
#(
  parameter int unsigned ROWS = 32,
  localparam int unsigned AddrW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [AddrW-1:0]    rd_addr_i,
  output logic [RowBitsW-1:0] rd_data_o,
  input  logic                wr_en_i,
  input  logic [AddrW-1:0]    wr_addr_i,
  input  logic [RowBitsW-1:0] wr_data_i
);

  logic [RowBitsW-1:0] mem_q [ROWS];
  logic [RowBitsW-1:0] rd_data_q;
  logic [ROWS-1:0]     valid_q;
  logic                rd_valid_q;

  // memory array, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // per-row valid bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  // a row never written reads as blank
  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

// ===== rtl/rdsr_span_gen.sv =====
// ----------------------------------------------------------------------------
// rdsr_span_gen
// Walks the turned-off word then the turned-on word one column a cycle
// unless a closing run waits on a full output register, closes maximal
// runs and drives one scaled rectangle per run through that register.
// ----------------------------------------------------------------------------
module rdsr_span_gen
  import rdsr_pkg::*;
#(
  parameter int unsigned COLUMNS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  span_cmd_t         cmd_i,
  output logic              busy_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CoordW-1:0] rect_x_o,
  output logic [CoordW-1:0] rect_y_o,
  output logic [WidthW-1:0] rect_w_o,
  output logic [ScaleW-1:0] rect_h_o,
  output logic              lit_color_o,
  output logic              last_span_o
);

  localparam logic [ColIdxW-1:0] LastCol = ColIdxW'(COLUMNS - 1);

  typedef enum logic [1:0] {
    GenIdle,
    GenOff,
    GenOn
  } gen_state_e;

  gen_state_e          state_q;
  logic [RowBitsW-1:0] sh_q;
  logic [RowBitsW-1:0] on_q;
  logic [ColIdxW-1:0]  x_q;
  logic                in_run_q;
  logic [ColIdxW-1:0]  start_q;
  logic [RunLenW-1:0]  len_q;
  logic [CoordW-1:0]   y_q;
  logic [ScaleW-1:0]   scale_q;
  logic [OriginW-1:0]  ox_q;

  logic                out_valid_q;
  logic [CoordW-1:0]   rect_x_q;
  logic [CoordW-1:0]   rect_y_q;
  logic [WidthW-1:0]   rect_w_q;
  logic [ScaleW-1:0]   rect_h_q;
  logic                color_q;
  logic                last_q;

  logic                active;
  logic                bit_cur;
  logic                last_col;
  logic                run_end;
  logic                out_free;
  logic                advance;
  logic                emit;
  logic                phase_done;
  logic                is_last;
  logic [ColIdxW-1:0]  end_start;
  logic [RunLenW-1:0]  end_len;
  logic [OriginW-1:0]  x_prod;
  logic [CoordW-1:0]   w_prod;

  // run detection on the current column
  always_comb begin
    active     = (state_q != GenIdle);
    bit_cur    = sh_q[RowBitsW-1];
    last_col   = (x_q == LastCol);
    run_end    = active && ((in_run_q && !bit_cur) || (bit_cur && last_col));
    out_free   = !out_valid_q || out_ready_i;
    advance    = active && (!run_end || out_free);
    emit       = run_end && out_free;
    phase_done = last_col || (!in_run_q && (sh_q == '0));
    end_start  = in_run_q ? start_q : x_q;
    end_len    = (in_run_q ? len_q : '0) + RunLenW'(bit_cur);
    // nothing left in this word, and for black runs no white ones to follow
    is_last    = (sh_q[RowBitsW-2:0] == '0) && ((state_q == GenOn) || (on_q == '0));
    x_prod     = OriginW'(end_start) * OriginW'(scale_q);
    w_prod     = CoordW'(end_len) * CoordW'(scale_q);
  end

  // scan state machine and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= GenIdle;
      sh_q        <= '0;
      on_q        <= '0;
      x_q         <= '0;
      in_run_q    <= 1'b0;
      start_q     <= '0;
      len_q       <= '0;
      y_q         <= '0;
      scale_q     <= '0;
      ox_q        <= '0;
      out_valid_q <= 1'b0;
      rect_x_q    <= '0;
      rect_y_q    <= '0;
      rect_w_q    <= '0;
      rect_h_q    <= '0;
      color_q     <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      case (state_q)
        GenIdle: begin
          if (start_i) begin
            state_q  <= GenOff;
            sh_q     <= cmd_i.off_bits;
            on_q     <= cmd_i.on_bits;
            x_q      <= '0;
            in_run_q <= 1'b0;
            y_q      <= cmd_i.rect_y;
            scale_q  <= cmd_i.scale;
            ox_q     <= cmd_i.origin_x;
          end
        end
        GenOff, GenOn: begin
          if (advance) begin
            if (phase_done) begin
              x_q      <= '0;
              in_run_q <= 1'b0;
              if (state_q == GenOff) begin
                state_q <= GenOn;
                sh_q    <= on_q;
              end else begin
                state_q <= GenIdle;
              end
            end else begin
              sh_q     <= sh_q << 1;
              x_q      <= x_q + 1'b1;
              in_run_q <= bit_cur;
              if (bit_cur && !in_run_q) begin
                start_q <= x_q;
                len_q   <= RunLenW'(1);
              end else if (bit_cur) begin
                len_q <= len_q + 1'b1;
              end
            end
          end
        end
        default: state_q <= GenIdle;
      endcase

      // rectangle transaction
      if (emit) begin
        out_valid_q <= 1'b1;
        rect_x_q    <= CoordW'(ox_q) + CoordW'(x_prod);
        rect_y_q    <= y_q;
        rect_w_q    <= w_prod[WidthW-1:0];
        rect_h_q    <= scale_q;
        color_q     <= (state_q == GenOn);
        last_q      <= is_last;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign busy_o      = active;
  assign out_valid_o = out_valid_q;
  assign rect_x_o    = rect_x_q;
  assign rect_y_o    = rect_y_q;
  assign rect_w_o    = rect_w_q;
  assign rect_h_o    = rect_h_q;
  assign lit_color_o = color_q;
  assign last_span_o = last_q;

endmodule
